[rtl/ffas_pkg.sv]
// Shared types and constants of the first-fit aligned suballocator.
package ffas_pkg;

    // Table geometry
    localparam int unsigned MAX_BLOCKS = 8;
    localparam int unsigned MAX_SLOTS  = 16;
    localparam int unsigned BLK_W      = 3;
    localparam int unsigned SLOT_W     = 4;
    localparam int unsigned ENTRY_W    = BLK_W + SLOT_W;
    localparam int unsigned RANK_W     = 5;
    localparam int unsigned ENTRIES    = MAX_BLOCKS * MAX_SLOTS;

    // Rank of the end mark in the gap walk; start mark is rank 0
    localparam logic [RANK_W-1:0] RANK_END = RANK_W'(MAX_SLOTS + 1);

    localparam logic [31:0] MIN_BLOCK_RESET = 32'd1048576;

    // Opcodes
    localparam logic OP_RESERVE = 1'b0;
    localparam logic OP_RETURN  = 1'b1;

    // Status codes
    localparam logic [2:0] ST_EXISTING  = 3'd0;
    localparam logic [2:0] ST_NEW_BLOCK = 3'd1;
    localparam logic [2:0] ST_RETURNED  = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic        opcode;
        logic [31:0] request_size;
        logic [31:0] align_bytes;
        logic [4:0]  mem_type;
        logic [3:0]  target_block;
        logic [4:0]  target_slot;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  granted_block;
        logic [4:0]  granted_slot;
        logic [31:0] granted_offset;
        logic [31:0] new_block_bytes;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BLK,
        S_RD,
        S_EV,
        S_GAP,
        S_DIV,
        S_FIT,
        S_NEWB
    } t_state;

endpackage

[rtl/ffas_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ffas_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ffas_rem.sv]
// Iterative restoring remainder unit, one dividend bit per cycle.
module ffas_rem (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_rem
);

    logic [32:0] r_dvd;
    logic [31:0] r_dsr;
    logic [31:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_run;
    logic        r_done;
    logic [32:0] trial;
    logic [32:0] diff;

    // Shift in the next dividend bit and try the subtraction
    assign trial = {r_rem, r_dvd[32]};
    assign diff  = trial - {1'b0, r_dsr};

    // Control: run for one cycle per dividend bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= 6'd33;
            end else if (r_run) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and dividend shifter
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_run) begin
            r_dvd <= {r_dvd[31:0], 1'b0};
            if (trial >= {1'b0, r_dsr}) begin
                r_rem <= diff[31:0];
            end else begin
                r_rem <= trial[31:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[rtl/first_fit_aligned_suballocator.sv]
// Top level: block table, reservation walk sequencer and configuration port.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+---------------------------
//  request   | start / busy            | i_req  (t_req)
//  result    | o_done (one-cycle pulse)| o_res  (t_res)
//  config    | psel/penable/pwrite     | paddr, pwdata, prdata
//
//  A return request finishes at its accepting edge; its result pulses in the next cycle.
//  A reserve request visits the blocks in turn in S_BLK; in a matching block each gap
//  takes a slot RAM scan in S_RD and S_EV plus a gap test in S_GAP, and a gap that is
//  not empty adds a fit test in S_FIT, preceded by the remainder unit in S_DIV when aligned.
//  With no fit, S_NEWB creates the block or reports full.
//  Synchronous active-low reset clears the table; the receiver cannot stall.
module first_fit_aligned_suballocator
    import ffas_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_done,
    output t_res        o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // State and table
    t_state              r_state, n_state;
    t_req                r_req, n_req;
    logic [31:0]         r_min;
    logic [3:0]          r_block_count;
    logic [4:0]          r_kind   [MAX_BLOCKS];
    logic [31:0]         r_bbytes [MAX_BLOCKS];
    logic [ENTRIES-1:0]  r_live;
    logic [15:0]         r_freed  [MAX_BLOCKS];
    logic [4:0]          r_lcnt   [MAX_BLOCKS];

    // Walk registers
    logic [3:0]          r_blk, n_blk;
    logic [RANK_W-1:0]   r_rank, n_rank;
    logic [31:0]         r_cur_off, n_cur_off, r_cur_len, n_cur_len;
    logic [RANK_W-1:0]   r_cur_rank, n_cur_rank;
    logic [31:0]         r_bst_off, n_bst_off, r_bst_len, n_bst_len;
    logic [RANK_W-1:0]   r_bst_rank, n_bst_rank;
    logic                r_found, n_found;
    logic [33:0]         r_left, n_left;
    logic                r_done, n_done;
    t_res                r_res, n_res;

    // Datapath signals
    logic [BLK_W-1:0]    blk_i;
    logic [SLOT_W-1:0]   rd_slot;
    logic [63:0]         ram_rd;
    logic [31:0]         ev_off, ev_len;
    logic                ev_live, ev_take;
    logic [32:0]         gap_left;
    logic [33:0]         right_ext, adj_left;
    logic                fit;
    logic [4:0]          nid;
    logic                freed_any;
    logic                div_start, div_done;
    logic [31:0]         div_rem;
    logic                do_place, do_create, do_ret;
    logic                ret_hit;
    logic [BLK_W-1:0]    ret_b;
    logic [SLOT_W-1:0]   ret_s;
    logic [31:0]         new_bytes;
    logic                ram_we;
    logic [ENTRY_W-1:0]  ram_waddr;
    logic [63:0]         ram_wdata;
    logic                cfg_wr;

    assign blk_i   = r_blk[BLK_W-1:0];
    assign rd_slot = SLOT_W'(r_rank - RANK_W'(1));

    // Slot RAM: {start, bytes} per reservation entry
    ffas_ram #(
        .WIDTH(64),
        .DEPTH(ENTRIES)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr({blk_i, rd_slot}),
        .o_rdata(ram_rd)
    );

    // Alignment remainder unit
    ffas_rem u_rem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(gap_left),
        .i_divisor (r_req.align_bytes),
        .o_done    (div_done),
        .o_rem     (div_rem)
    );

    // Element under evaluation: start mark, reservation or end mark
    always_comb begin
        if (r_rank == '0) begin
            ev_off  = '0;
            ev_len  = '0;
            ev_live = 1'b1;
        end else if (r_rank == RANK_END) begin
            ev_off  = r_bbytes[blk_i];
            ev_len  = '0;
            ev_live = 1'b1;
        end else begin
            ev_off  = ram_rd[63:32];
            ev_len  = ram_rd[31:0];
            ev_live = r_live[{blk_i, rd_slot}];
        end
    end

    // Keep the smallest key above the current one
    assign ev_take = ev_live && ({ev_off, r_rank} > {r_cur_off, r_cur_rank})
                     && (!r_found || ({ev_off, r_rank} < {r_bst_off, r_bst_rank}));

    // Gap bounds and fit test
    assign gap_left  = {1'b0, r_cur_off} + {1'b0, r_cur_len};
    assign right_ext = {2'b00, r_bst_off};
    assign adj_left  = (div_rem != '0)
                     ? {1'b0, gap_left} + {2'b00, r_req.align_bytes - div_rem}
                     : {1'b0, gap_left};
    assign fit = (r_left < right_ext)
              && ((right_ext - r_left) >= {2'b00, r_req.request_size});

    // Smallest freed id, else live count + 1
    always_comb begin
        nid       = r_lcnt[blk_i] + 5'd1;
        freed_any = 1'b0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if (r_freed[blk_i][i] && !freed_any) begin
                nid       = 5'(i + 1);
                freed_any = 1'b1;
            end
        end
    end

    // Return lookup
    assign ret_b   = BLK_W'(i_req.target_block - 4'd1);
    assign ret_s   = SLOT_W'(i_req.target_slot - 5'd1);
    assign ret_hit = (i_req.target_block != '0) && (i_req.target_block <= r_block_count)
                  && (i_req.target_slot != '0) && (i_req.target_slot <= 5'(MAX_SLOTS))
                  && r_live[{ret_b, ret_s}];

    assign new_bytes = (r_req.request_size > r_min) ? r_req.request_size : r_min;

    // Slot RAM write on place or create
    always_comb begin
        ram_we    = do_place || do_create;
        ram_waddr = do_create ? {r_block_count[BLK_W-1:0], SLOT_W'(0)}
                              : {blk_i, SLOT_W'(nid - 5'd1)};
        ram_wdata = do_create ? {32'd0, r_req.request_size}
                              : {r_left[31:0], r_req.request_size};
    end

    // Sequencer: next state and walk control
    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_blk      = r_blk;
        n_rank     = r_rank;
        n_cur_off  = r_cur_off;
        n_cur_len  = r_cur_len;
        n_cur_rank = r_cur_rank;
        n_bst_off  = r_bst_off;
        n_bst_len  = r_bst_len;
        n_bst_rank = r_bst_rank;
        n_found    = r_found;
        n_left     = r_left;
        n_done     = 1'b0;
        n_res      = r_res;
        div_start  = 1'b0;
        do_place   = 1'b0;
        do_create  = 1'b0;
        do_ret     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    if (i_req.opcode == OP_RETURN) begin
                        do_ret        = ret_hit;
                        n_done        = 1'b1;
                        n_res         = '0;
                        n_res.status  = ret_hit ? ST_RETURNED : ST_NOT_FOUND;
                    end else begin
                        n_blk   = '0;
                        n_state = S_BLK;
                    end
                end
            end
            S_BLK: begin
                if (r_blk == r_block_count) begin
                    n_state = S_NEWB;
                end else if (r_kind[blk_i] != r_req.mem_type
                             || r_lcnt[blk_i] >= 5'(MAX_SLOTS)) begin
                    n_blk = r_blk + 4'd1;
                end else begin
                    n_cur_off  = '0;
                    n_cur_len  = '0;
                    n_cur_rank = '0;
                    n_rank     = '0;
                    n_found    = 1'b0;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                if (ev_take) begin
                    n_bst_off  = ev_off;
                    n_bst_len  = ev_len;
                    n_bst_rank = r_rank;
                    n_found    = 1'b1;
                end
                if (r_rank == RANK_END) begin
                    n_state = S_GAP;
                end else begin
                    n_rank  = r_rank + RANK_W'(1);
                    n_state = S_RD;
                end
            end
            S_GAP: begin
                if (!r_found) begin
                    n_blk   = r_blk + 4'd1;
                    n_state = S_BLK;
                end else if (gap_left >= {1'b0, r_bst_off}) begin
                    n_cur_off  = r_bst_off;
                    n_cur_len  = r_bst_len;
                    n_cur_rank = r_bst_rank;
                    n_rank     = '0;
                    n_found    = 1'b0;
                    n_state    = S_RD;
                end else if (r_req.align_bytes == '0) begin
                    n_left  = {1'b0, gap_left};
                    n_state = S_FIT;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_left  = adj_left;
                    n_state = S_FIT;
                end
            end
            S_FIT: begin
                if (fit) begin
                    do_place             = 1'b1;
                    n_done               = 1'b1;
                    n_res                = '0;
                    n_res.status         = ST_EXISTING;
                    n_res.granted_block  = r_blk + 4'd1;
                    n_res.granted_slot   = nid;
                    n_res.granted_offset = r_left[31:0];
                    n_state              = S_IDLE;
                end else begin
                    n_cur_off  = r_bst_off;
                    n_cur_len  = r_bst_len;
                    n_cur_rank = r_bst_rank;
                    n_rank     = '0;
                    n_found    = 1'b0;
                    n_state    = S_RD;
                end
            end
            S_NEWB: begin
                n_done = 1'b1;
                n_res  = '0;
                if (r_block_count >= 4'(MAX_BLOCKS)) begin
                    n_res.status = ST_FULL;
                end else begin
                    do_create             = 1'b1;
                    n_res.status          = ST_NEW_BLOCK;
                    n_res.granted_block   = r_block_count + 4'd1;
                    n_res.granted_slot    = 5'd1;
                    n_res.new_block_bytes = new_bytes;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Walk and result payload
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_blk      <= n_blk;
        r_rank     <= n_rank;
        r_cur_off  <= n_cur_off;
        r_cur_len  <= n_cur_len;
        r_cur_rank <= n_cur_rank;
        r_bst_off  <= n_bst_off;
        r_bst_len  <= n_bst_len;
        r_bst_rank <= n_bst_rank;
        r_found    <= n_found;
        r_left     <= n_left;
        r_res      <= n_res;
    end

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);

    // Table bookkeeping: minimum block size, live bits, freed ids, counts, block count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min         <= MIN_BLOCK_RESET;
            r_block_count <= '0;
            r_live        <= '0;
            for (int b = 0; b < MAX_BLOCKS; b++) begin
                r_freed[b] <= '0;
                r_lcnt[b]  <= '0;
            end
        end else begin
            if (cfg_wr) begin
                r_min <= pwdata;
            end
            if (do_ret) begin
                r_live[{ret_b, ret_s}] <= 1'b0;
                r_freed[ret_b][ret_s]  <= 1'b1;
                r_lcnt[ret_b]          <= r_lcnt[ret_b] - 5'd1;
            end
            if (do_place) begin
                r_live[{blk_i, SLOT_W'(nid - 5'd1)}] <= 1'b1;
                r_freed[blk_i][SLOT_W'(nid - 5'd1)]  <= 1'b0;
                r_lcnt[blk_i]                        <= r_lcnt[blk_i] + 5'd1;
            end
            if (do_create) begin
                r_live[{r_block_count[BLK_W-1:0], SLOT_W'(0)} +: MAX_SLOTS]
                    <= MAX_SLOTS'(1);
                r_freed[r_block_count[BLK_W-1:0]] <= '0;
                r_lcnt[r_block_count[BLK_W-1:0]]  <= 5'd1;
                r_block_count                     <= r_block_count + 4'd1;
            end
        end
    end

    // Block descriptors, written on creation
    always_ff @(posedge i_clk) begin
        if (do_create) begin
            r_kind[r_block_count[BLK_W-1:0]]   <= r_req.mem_type;
            r_bbytes[r_block_count[BLK_W-1:0]] <= new_bytes;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? r_min : 32'd0;

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result pulse while still walking");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_block_count <= 4'(MAX_BLOCKS))
        else $error("block count beyond table size");

    a_new_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status == ST_NEW_BLOCK)
        |-> (o_res.granted_slot == 5'd1 && o_res.granted_offset == '0))
        else $error("new block result not at slot one offset zero");

    a_ret_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.opcode == OP_RETURN) |=> o_done)
        else $error("return request did not complete in one cycle");
`endif

endmodule

[test/first_fit_aligned_suballocator_test.sv]
// Testbench for the first-fit aligned suballocator: random and directed requests checked against a predictor.
module first_fit_aligned_suballocator_test
    import ffas_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_req = '0;
    logic        o_done;
    t_res        o_res;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    localparam logic [2:0] ADDR_MIN_BLOCK = 3'd0;

    first_fit_aligned_suballocator i_dut (.*);

    always #10 i_clk = ~i_clk;

    // Predictor state of the block table
    logic [31:0] pm_min_block;
    int unsigned pm_blocks;
    logic [4:0]  pm_kind [MAX_BLOCKS];
    longint unsigned pm_bytes [MAX_BLOCKS];
    bit          pm_live [ENTRIES];
    longint unsigned pm_start [ENTRIES];
    longint unsigned pm_len [ENTRIES];
    logic [15:0] pm_freed [MAX_BLOCKS];
    int unsigned pm_count [MAX_BLOCKS];

    t_req pending_reqs[$];
    t_res expected_results[$];
    int   errors = 0;
    bit   hold_off = 1'b0;
    int   gap_left = 0;

    // Append a request to the pending queue
    function automatic void queue_req(t_req r);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    function automatic void clear_table();
        pm_blocks = 0;
        for (int i = 0; i < ENTRIES; i++) pm_live[i] = 1'b0;
        for (int b = 0; b < MAX_BLOCKS; b++) begin
            pm_freed[b] = '0;
            pm_count[b] = 0;
        end
    endfunction

    function automatic int unsigned claim_id(int unsigned b);
        for (int i = 0; i < MAX_SLOTS; i++)
            if (pm_freed[b][i]) begin
                pm_freed[b][i] = 1'b0;
                return i + 1;
            end
        return pm_count[b] + 1;
    endfunction

    // Walk the sorted gaps of one block and place the request if it fits
    function automatic bit place_in_block(int unsigned b, longint unsigned sz,
                                          longint unsigned al, output longint unsigned where,
                                          output int unsigned id);
        longint unsigned offs[MAX_SLOTS + 2];
        longint unsigned lens[MAX_SLOTS + 2];
        longint unsigned ko, kl, lo, hi;
        int n, j, e;
        n = 0;
        where = 0;
        id = 0;
        if (pm_count[b] >= MAX_SLOTS) return 1'b0;
        offs[0] = 0; lens[0] = 0; n = 1;
        for (int p = 0; p < MAX_SLOTS; p++) begin
            e = b * MAX_SLOTS + p;
            if (pm_live[e]) begin
                offs[n] = pm_start[e]; lens[n] = pm_len[e]; n++;
            end
        end
        offs[n] = pm_bytes[b]; lens[n] = 0; n++;
        for (int i = 1; i < n; i++) begin
            ko = offs[i]; kl = lens[i]; j = i;
            while (j > 0 && offs[j-1] > ko) begin
                offs[j] = offs[j-1]; lens[j] = lens[j-1]; j--;
            end
            offs[j] = ko; lens[j] = kl;
        end
        for (int k = 0; k + 1 < n; k++) begin
            lo = offs[k] + lens[k];
            hi = offs[k+1];
            if (al != 0 && lo % al != 0) lo += al - lo % al;
            if (lo < hi && hi - lo >= sz) begin
                id = claim_id(b);
                if (id < 1 || id > MAX_SLOTS) return 1'b0;
                e = b * MAX_SLOTS + id - 1;
                pm_live[e] = 1'b1;
                pm_start[e] = lo;
                pm_len[e] = sz;
                pm_count[b]++;
                where = lo;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_res predict_grant(t_req r);
        t_res res;
        longint unsigned where, nb;
        int unsigned id, e;
        res = '0;
        if (r.opcode == OP_RETURN) begin
            res.status = ST_NOT_FOUND;
            if (r.target_block >= 1 && r.target_block <= pm_blocks &&
                r.target_slot >= 1 && r.target_slot <= MAX_SLOTS) begin
                e = (r.target_block - 1) * MAX_SLOTS + r.target_slot - 1;
                if (pm_live[e]) begin
                    pm_live[e] = 1'b0;
                    pm_freed[r.target_block-1][r.target_slot-1] = 1'b1;
                    pm_count[r.target_block-1]--;
                    res.status = ST_RETURNED;
                end
            end
            return res;
        end
        for (int unsigned b = 0; b < pm_blocks; b++) begin
            if (pm_kind[b] != r.mem_type) continue;
            if (place_in_block(b, r.request_size, r.align_bytes, where, id)) begin
                res.status = ST_EXISTING;
                res.granted_block = 4'(b + 1);
                res.granted_slot = 5'(id);
                res.granted_offset = where[31:0];
                return res;
            end
        end
        nb = (r.request_size > pm_min_block) ? r.request_size : pm_min_block;
        if (pm_blocks >= MAX_BLOCKS) begin
            res.status = ST_FULL;
            return res;
        end
        pm_kind[pm_blocks] = r.mem_type;
        pm_bytes[pm_blocks] = nb;
        pm_freed[pm_blocks] = '0;
        for (int i = 0; i < MAX_SLOTS; i++) pm_live[pm_blocks * MAX_SLOTS + i] = 1'b0;
        e = pm_blocks * MAX_SLOTS;
        pm_live[e] = 1'b1;
        pm_start[e] = 0;
        pm_len[e] = r.request_size;
        pm_count[pm_blocks] = 1;
        pm_blocks++;
        res.status = ST_NEW_BLOCK;
        res.granted_block = 4'(pm_blocks);
        res.granted_slot = 5'd1;
        res.new_block_bytes = nb[31:0];
        return res;
    endfunction

    // Driver: hold each request until accepted, then wait a random gap
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_results.insert(expected_results.size(), predict_grant(i_req));
                start <= 1'b0;
                gap_left <= $urandom_range(0, 11);
            end else if (!start) begin
                if (gap_left > 0) gap_left <= gap_left - 1;
                else if (!hold_off && pending_reqs.size() > 0) begin
                    i_req <= pending_reqs.pop_front();
                    start <= 1'b1;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_res);
                errors++;
            end else begin
                t_res want;
                want = expected_results.pop_front();
                if (o_res !== want) begin
                    $display("%0t: expected %h actual %h", $time, want, o_res);
                    errors++;
                end
            end
        end
    end

    task automatic write_min_block(logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_MIN_BLOCK; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        pm_min_block = value;
    endtask

    // Wait at the falling edge so driver and monitor updates have settled
    task automatic drain();
        while (pending_reqs.size() > 0 || start || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    function automatic t_req make_reserve(logic [31:0] sz, logic [31:0] al, logic [4:0] mt);
        t_req r;
        r = '0;
        r.opcode = OP_RESERVE;
        r.request_size = sz;
        r.align_bytes = al;
        r.mem_type = mt;
        r.target_block = 4'($urandom);
        r.target_slot = 5'($urandom);
        return r;
    endfunction

    function automatic t_req make_return(logic [3:0] blk, logic [4:0] slot);
        t_req r;
        r = '0;
        r.opcode = OP_RETURN;
        r.request_size = $urandom;
        r.align_bytes = $urandom;
        r.mem_type = 5'($urandom);
        r.target_block = blk;
        r.target_slot = slot;
        return r;
    endfunction

    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return $urandom;
            2: return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    function automatic logic [31:0] pick_align();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return $urandom;
            2: return 32'hFFFF_FFFF;
            default: return 32'd1 << $urandom_range(0, 12);
        endcase
    endfunction

    initial begin
        logic [31:0] min_sizes [4];
        pm_min_block = MIN_BLOCK_RESET;
        clear_table();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, zero size, equal offsets, full table, unknown returns
        queue_req(make_return(4'd1, 5'd1));
        queue_req(make_reserve(32'd0, 32'd0, 5'd0));
        queue_req(make_reserve(32'd0, 32'd0, 5'd0));
        queue_req(make_reserve(32'd100, 32'd64, 5'd0));
        queue_req(make_reserve(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31));
        queue_req(make_reserve(32'd1, 32'h8000_0000, 5'd31));
        queue_req(make_return(4'd1, 5'd2));
        queue_req(make_return(4'd1, 5'd2));
        queue_req(make_return(4'd0, 5'd1));
        queue_req(make_return(4'd15, 5'd31));
        queue_req(make_return(4'd1, 5'd0));
        queue_req(make_return(4'd1, 5'd17));
        queue_req(make_reserve(32'd8, 32'd0, 5'd0));
        for (int i = 0; i < 8; i++)
            queue_req(make_reserve(32'h0020_0000, 32'd0, 5'(i + 1)));
        drain();

        // Random phases under several minimum block sizes
        min_sizes[0] = 32'd0;
        min_sizes[1] = 32'hFFFF_FFFF;
        min_sizes[2] = 32'd4096;
        min_sizes[3] = 32'd65536;
        for (int ph = 0; ph < 4; ph++) begin
            // Reset-free phase: set a new minimum block size, then mix random returns and reserves
            write_min_block(min_sizes[ph]);
            for (int i = 0; i < 500; i++) begin
                if ($urandom_range(0, 2) == 0)
                    queue_req(make_return(4'($urandom_range(0, 9)),
                                          5'($urandom_range(0, 17))));
                else if ($urandom_range(0, 19) == 0)
                    queue_req(make_return(4'($urandom), 5'($urandom)));
                else
                    queue_req(make_reserve(pick_size(), pick_align(),
                                           5'($urandom_range(0, 3) == 0 ?
                                              $urandom : $urandom_range(0, 3))));
                if (i == 250) begin
                    // Pause until every expected result has come
                    while (pending_reqs.size() > 0 || start) @(negedge i_clk);
                    hold_off = 1'b1;
                    while (expected_results.size() > 0) @(negedge i_clk);
                    hold_off = 1'b0;
                end
            end
            drain();
        end
        if (errors == 0)
            $display("first_fit_aligned_suballocator_test OK");
        else
            $display("first_fit_aligned_suballocator_test NOT OK");
        $finish;
    end

    initial begin
        #(64'd20 * 64'd100_000_000);
        $display("first_fit_aligned_suballocator_test NOT OK");
        $finish;
    end

endmodule
